### hdl/interval_remap_splitter_top_defines.svh
// assertion macros for the interval remap splitter top level
// no dependencies; the including module provides aclk and aresetn
`ifndef INTERVAL_REMAP_SPLITTER_TOP_DEFINES_SVH
`define INTERVAL_REMAP_SPLITTER_TOP_DEFINES_SVH

// condition true at every edge out of reset
`define IRS_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("irs: invariant violated");

// same-cycle implication
`define IRS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("irs: implication violated");

// next-cycle implication
`define IRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("irs: next-cycle implication violated");

`endif

### hdl/irs_pkg.sv
// shared types, constants and helpers for the interval remap splitter
// no dependencies
package irs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_WIDTH  = 48;
    localparam int FIELD_W     = 48;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PC_W        = 5;

    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [PC_W-1:0]       pc_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SPLIT = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_PIECE = 2'd0,
        ST_OK    = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    // one table entry: half-open source interval and its shift
    typedef struct packed {
        addr_t low;
        addr_t high;
        addr_t offset;
    } region_t;

    // datapath micro-operations
    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD,
        A_RD_I,
        A_BOUNDS,
        A_PUT_UNMAP,
        A_PUT_MAP,
        A_ADVANCE,
        A_PUT_TAIL,
        A_FLUSH,
        A_CLEAR_OK,
        A_RD_POS,
        A_SHIFT,
        A_INSERT_OK,
        A_REJECT
    } act_e;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACC,
        C_OP_CLEAR,
        C_OP_ADD,
        C_OP_NSPLIT,
        C_SPLIT_DONE,
        C_LE_LE_S,
        C_IE_LE_B,
        C_S_GE_E,
        C_FULL,
        C_POS_ZERO,
        C_LOW_LE_SRC
    } cond_e;

    typedef struct packed {
        act_e  act;
        cond_e cond;
        pc_t   target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic no_acc;
        logic op_clear;
        logic op_add;
        logic op_nsplit;
        logic split_done;
        logic le_le_s;
        logic ie_le_b;
        logic s_ge_e;
        logic full;
        logic pos_zero;
        logic low_le_src;
    } flags_t;

    function automatic addr_t to_addr(field_t v);
        logic [ADDR_WIDTH+FIELD_W-1:0] w;
        w = {{ADDR_WIDTH{1'b0}}, v};
        return w[ADDR_WIDTH-1:0];
    endfunction

    function automatic field_t to_field(addr_t a);
        logic [ADDR_WIDTH+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, a};
        return w[FIELD_W-1:0];
    endfunction

    // a + len, clamped at the address limit
    function automatic addr_t sat_end(addr_t a, addr_t len);
        logic [ADDR_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, len};
        return s[ADDR_WIDTH] ? '1 : s[ADDR_WIDTH-1:0];
    endfunction

endpackage

### hdl/interval_remap_splitter_top.sv
// interval remap splitter top level: region table, datapath and output stage
// depends on irs_pkg, irs_seq and interval_remap_splitter_top_defines.svh
//
// usage
//   input channel s_*: one word carries an operation and its operands.
//     clear empties the table, add inserts a region sorted by source start,
//     split cuts [range_start, range_start+range_length) against the table.
//   output channel m_*: zero or more words per input, m_last on the final one.
//     clear and add give a single status word; split gives its pieces in
//     address order, shifted pieces with m_mapped set, and nothing when empty.
//   one item at a time: s_ready is high only at the sequencer's idle step.
//     the control program visits one table entry per pass through the region
//     memory, which has one write port and one registered read port.
//   a finished word sits in the output register; when the receiver stalls,
//     the next piece waits in a one-word hold stage and the sequencer stops
//     only at the step that needs the output register.
//   reset (aresetn low, synchronous) empties the table and drops any word in
//     flight; table contents are not cleared, only the entry count.
`include "interval_remap_splitter_top_defines.svh"

module interval_remap_splitter_top (
    input  logic            aclk,
    input  logic            aresetn,
    // input words
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_operation,
    input  irs_pkg::field_t s_entry_dest,
    input  irs_pkg::field_t s_entry_source,
    input  irs_pkg::field_t s_entry_length,
    input  irs_pkg::field_t s_range_start,
    input  irs_pkg::field_t s_range_length,
    // result words
    output logic            m_valid,
    input  logic            m_ready,
    output irs_pkg::field_t m_piece_start,
    output irs_pkg::field_t m_piece_end,
    output logic            m_mapped,
    output logic [1:0]      m_status,
    output logic            m_last
);
    import irs_pkg::*;

    // sequencer interface
    act_e   act;
    flags_t flags;
    logic   stall;
    logic   go;
    logic   needs_out;

    // latched operands
    logic [1:0] op_reg,  op_next;
    addr_t      src_reg, src_next;   // new region start
    addr_t      hi_reg,  hi_next;    // new region end
    addr_t      off_reg, off_next;   // new region shift
    addr_t      s_reg,   s_next;     // split cursor
    addr_t      e_reg,   e_next;     // split end
    cnt_t       i_reg,   i_next;     // split entry index
    cnt_t       pos_reg, pos_next;   // insert position
    cnt_t       cnt_reg, cnt_next;   // entries in use
    cnt_t       pos_m1;

    // per-region bounds for the current split pass
    addr_t le_reg, le_next;
    addr_t b_reg,  b_next;
    addr_t ie_reg, ie_next;

    // region memory, single write and single registered read
    region_t mem [TABLE_DEPTH];
    region_t rd_reg;
    logic    rd_en;
    idx_t    raddr;
    logic    we;
    idx_t    waddr;
    region_t wdata;

    // one-word hold stage, so the final piece can be tagged last
    logic  pend_v_reg,      pend_v_next;
    addr_t pend_start_reg,  pend_start_next;
    addr_t pend_end_reg,    pend_end_next;
    logic  pend_mapped_reg, pend_mapped_next;

    // output register
    logic    out_v_reg,      out_v_next;
    addr_t   out_start_reg,  out_start_next;
    addr_t   out_end_reg,    out_end_next;
    logic    out_mapped_reg, out_mapped_next;
    status_e out_status_reg, out_status_next;
    logic    out_last_reg,   out_last_next;

    irs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .stall   (stall),
        .act     (act)
    );

    assign s_ready = (act == A_LOAD);
    assign pos_m1  = pos_reg - cnt_t'(1);

    // a step that must write the output register waits for it to free up
    always_comb begin
        needs_out = 1'b0;
        case (act)
            A_PUT_UNMAP, A_PUT_MAP, A_PUT_TAIL, A_FLUSH: needs_out = pend_v_reg;
            A_CLEAR_OK, A_INSERT_OK, A_REJECT:           needs_out = 1'b1;
            default:                                     needs_out = 1'b0;
        endcase
    end

    assign stall = needs_out && out_v_reg && !m_ready;
    assign go    = !stall;

    always_comb begin
        flags.no_acc     = !s_valid;
        flags.op_clear   = (op_reg == OP_CLEAR);
        flags.op_add     = (op_reg == OP_ADD);
        flags.op_nsplit  = (op_reg != OP_SPLIT);
        flags.split_done = (i_reg >= cnt_reg) || (s_reg >= e_reg);
        flags.le_le_s    = (le_reg <= s_reg);
        flags.ie_le_b    = (ie_reg <= b_reg);
        flags.s_ge_e     = (s_reg >= e_reg);
        flags.full       = (cnt_reg >= cnt_t'(TABLE_DEPTH));
        flags.pos_zero   = (pos_reg == '0);
        flags.low_le_src = (rd_reg.low <= src_reg);
    end

    always_comb begin
        op_next          = op_reg;
        src_next         = src_reg;
        hi_next          = hi_reg;
        off_next         = off_reg;
        s_next           = s_reg;
        e_next           = e_reg;
        i_next           = i_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        le_next          = le_reg;
        b_next           = b_reg;
        ie_next          = ie_reg;
        pend_v_next      = pend_v_reg;
        pend_start_next  = pend_start_reg;
        pend_end_next    = pend_end_reg;
        pend_mapped_next = pend_mapped_reg;
        out_v_next       = out_v_reg && !m_ready;
        out_start_next   = out_start_reg;
        out_end_next     = out_end_reg;
        out_mapped_next  = out_mapped_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        rd_en            = 1'b0;
        raddr            = i_reg[IDX_W-1:0];
        we               = 1'b0;
        waddr            = pos_reg[IDX_W-1:0];
        wdata            = rd_reg;

        // pieces pass through the hold stage, so the older one goes out first
        if (go && pend_v_reg && (act inside {A_PUT_UNMAP, A_PUT_MAP, A_PUT_TAIL, A_FLUSH})) begin
            out_v_next      = 1'b1;
            out_start_next  = pend_start_reg;
            out_end_next    = pend_end_reg;
            out_mapped_next = pend_mapped_reg;
            out_status_next = ST_PIECE;
            out_last_next   = (act == A_FLUSH);
        end

        case (act)
            A_LOAD: begin
                if (s_valid) begin
                    op_next  = s_operation;
                    src_next = to_addr(s_entry_source);
                    hi_next  = sat_end(to_addr(s_entry_source), to_addr(s_entry_length));
                    off_next = to_addr(s_entry_dest) - to_addr(s_entry_source);
                    s_next   = to_addr(s_range_start);
                    e_next   = sat_end(to_addr(s_range_start), to_addr(s_range_length));
                    i_next   = '0;
                    pos_next = cnt_reg;
                end
            end
            A_RD_I: begin
                rd_en = 1'b1;
                raddr = i_reg[IDX_W-1:0];
            end
            A_BOUNDS: begin
                le_next = (rd_reg.low < e_reg) ? rd_reg.low : e_reg;
                b_next  = (s_reg > rd_reg.low) ? s_reg : rd_reg.low;
                ie_next = (e_reg < rd_reg.high) ? e_reg : rd_reg.high;
            end
            A_PUT_UNMAP: begin
                if (go) begin
                    pend_v_next      = 1'b1;
                    pend_start_next  = s_reg;
                    pend_end_next    = le_reg;
                    pend_mapped_next = 1'b0;
                end
            end
            A_PUT_MAP: begin
                if (go) begin
                    pend_v_next      = 1'b1;
                    pend_start_next  = b_reg + rd_reg.offset;
                    pend_end_next    = ie_reg + rd_reg.offset;
                    pend_mapped_next = 1'b1;
                end
            end
            A_ADVANCE: begin
                if (rd_reg.high > s_reg) begin
                    s_next = rd_reg.high;
                end
                i_next = i_reg + cnt_t'(1);
            end
            A_PUT_TAIL: begin
                if (go) begin
                    pend_v_next      = 1'b1;
                    pend_start_next  = s_reg;
                    pend_end_next    = e_reg;
                    pend_mapped_next = 1'b0;
                end
            end
            A_FLUSH: begin
                if (go) begin
                    pend_v_next = 1'b0;
                end
            end
            A_CLEAR_OK: begin
                if (go) begin
                    cnt_next        = '0;
                    out_v_next      = 1'b1;
                    out_start_next  = '0;
                    out_end_next    = '0;
                    out_mapped_next = 1'b0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                end
            end
            A_RD_POS: begin
                rd_en = 1'b1;
                raddr = pos_m1[IDX_W-1:0];
            end
            A_SHIFT: begin
                we       = 1'b1;
                waddr    = pos_reg[IDX_W-1:0];
                wdata    = rd_reg;
                pos_next = pos_m1;
            end
            A_INSERT_OK: begin
                if (go) begin
                    we              = 1'b1;
                    waddr           = pos_reg[IDX_W-1:0];
                    wdata.low       = src_reg;
                    wdata.high      = hi_reg;
                    wdata.offset    = off_reg;
                    cnt_next        = cnt_reg + cnt_t'(1);
                    out_v_next      = 1'b1;
                    out_start_next  = '0;
                    out_end_next    = '0;
                    out_mapped_next = 1'b0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                end
            end
            A_REJECT: begin
                if (go) begin
                    out_v_next      = 1'b1;
                    out_start_next  = '0;
                    out_end_next    = '0;
                    out_mapped_next = 1'b0;
                    out_status_next = ST_FULL;
                    out_last_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // region memory
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_reg <= mem[raddr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        src_reg         <= src_next;
        hi_reg          <= hi_next;
        off_reg         <= off_next;
        s_reg           <= s_next;
        e_reg           <= e_next;
        i_reg           <= i_next;
        pos_reg         <= pos_next;
        le_reg          <= le_next;
        b_reg           <= b_next;
        ie_reg          <= ie_next;
        pend_start_reg  <= pend_start_next;
        pend_end_reg    <= pend_end_next;
        pend_mapped_reg <= pend_mapped_next;
        out_start_reg   <= out_start_next;
        out_end_reg     <= out_end_next;
        out_mapped_reg  <= out_mapped_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid       = out_v_reg;
    assign m_piece_start = to_field(out_start_reg);
    assign m_piece_end   = to_field(out_end_reg);
    assign m_mapped      = out_mapped_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

    // table never grows past its depth
    `IRS_ASSERT_HOLDS(a_cnt_bound, cnt_reg <= cnt_t'(TABLE_DEPTH))
    // no piece is left in the hold stage once the sequencer is back at idle
    `IRS_ASSERT_IMPLIES(a_idle_no_pend, s_ready, !pend_v_reg)
    // a status word always closes its input
    `IRS_ASSERT_IMPLIES(a_status_last, m_valid && (m_status != ST_PIECE), m_last)
    // only one item in flight
    `IRS_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

endmodule

### hdl/irs_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
// depends on irs_pkg
module irs_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  irs_pkg::flags_t flags,
    input  logic            stall,
    output irs_pkg::act_e   act
);
    import irs_pkg::*;

    localparam pc_t P_IDLE     = pc_t'(0);
    localparam pc_t P_SP_TOP   = pc_t'(4);
    localparam pc_t P_SKIP_U   = pc_t'(8);
    localparam pc_t P_ADVANCE  = pc_t'(10);
    localparam pc_t P_SP_END   = pc_t'(11);
    localparam pc_t P_FLUSH    = pc_t'(13);
    localparam pc_t P_CLR      = pc_t'(14);
    localparam pc_t P_ADD      = pc_t'(15);
    localparam pc_t P_INS_TOP  = pc_t'(16);
    localparam pc_t P_INS_PUT  = pc_t'(19);
    localparam pc_t P_REJ      = pc_t'(20);

    function automatic ucode_t uw(act_e a, cond_e c, pc_t t);
        ucode_t u;
        u.act    = a;
        u.cond   = c;
        u.target = t;
        return u;
    endfunction

    function automatic ucode_t rom(pc_t pc);
        ucode_t u;
        case (pc)
            5'd0:    u = uw(A_LOAD,      C_NO_ACC,     P_IDLE);
            5'd1:    u = uw(A_NOP,       C_OP_CLEAR,   P_CLR);
            5'd2:    u = uw(A_NOP,       C_OP_ADD,     P_ADD);
            5'd3:    u = uw(A_NOP,       C_OP_NSPLIT,  P_IDLE);
            // split loop, one region per pass
            5'd4:    u = uw(A_RD_I,      C_SPLIT_DONE, P_SP_END);
            5'd5:    u = uw(A_BOUNDS,    C_NEVER,      P_IDLE);
            5'd6:    u = uw(A_NOP,       C_LE_LE_S,    P_SKIP_U);
            5'd7:    u = uw(A_PUT_UNMAP, C_NEVER,      P_IDLE);
            5'd8:    u = uw(A_NOP,       C_IE_LE_B,    P_ADVANCE);
            5'd9:    u = uw(A_PUT_MAP,   C_NEVER,      P_IDLE);
            5'd10:   u = uw(A_ADVANCE,   C_ALWAYS,     P_SP_TOP);
            5'd11:   u = uw(A_NOP,       C_S_GE_E,     P_FLUSH);
            5'd12:   u = uw(A_PUT_TAIL,  C_NEVER,      P_IDLE);
            5'd13:   u = uw(A_FLUSH,     C_ALWAYS,     P_IDLE);
            5'd14:   u = uw(A_CLEAR_OK,  C_ALWAYS,     P_IDLE);
            // sorted insert, shifting larger entries up
            5'd15:   u = uw(A_NOP,       C_FULL,       P_REJ);
            5'd16:   u = uw(A_RD_POS,    C_POS_ZERO,   P_INS_PUT);
            5'd17:   u = uw(A_NOP,       C_LOW_LE_SRC, P_INS_PUT);
            5'd18:   u = uw(A_SHIFT,     C_ALWAYS,     P_INS_TOP);
            5'd19:   u = uw(A_INSERT_OK, C_ALWAYS,     P_IDLE);
            5'd20:   u = uw(A_REJECT,    C_ALWAYS,     P_IDLE);
            default: u = uw(A_NOP,       C_ALWAYS,     P_IDLE);
        endcase
        return u;
    endfunction

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t uc;
    logic   taken;

    assign uc  = rom(pc_reg);
    assign act = uc.act;

    always_comb begin
        case (uc.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_ACC:     taken = flags.no_acc;
            C_OP_CLEAR:   taken = flags.op_clear;
            C_OP_ADD:     taken = flags.op_add;
            C_OP_NSPLIT:  taken = flags.op_nsplit;
            C_SPLIT_DONE: taken = flags.split_done;
            C_LE_LE_S:    taken = flags.le_le_s;
            C_IE_LE_B:    taken = flags.ie_le_b;
            C_S_GE_E:     taken = flags.s_ge_e;
            C_FULL:       taken = flags.full;
            C_POS_ZERO:   taken = flags.pos_zero;
            C_LOW_LE_SRC: taken = flags.low_le_src;
            default:      taken = 1'b1;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (!stall) begin
            pc_next = taken ? uc.target : pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= P_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### verif/interval_remap_splitter_top_tb.sv
// testbench for interval_remap_splitter_top: directed and random clear, add and split words
// depends on irs_pkg and the dut; self-checking against an in-bench region table
`timescale 1ns / 1ps

module interval_remap_splitter_top_tb;
    import irs_pkg::*;

    // code the block ignores
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam field_t      FIELD_MAX    = '1;
    localparam int unsigned ITEM_TARGET  = 330;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned QUIET_LIMIT  = 5000;

    // one expected result word
    typedef struct {
        field_t  piece_start;
        field_t  piece_end;
        logic    mapped;
        status_e status;
        logic    last;
    } piece_t;

    // region table mirror and queue of expected result words
    class remap_scoreboard;
        field_t      lo_bound [TABLE_DEPTH];
        field_t      hi_bound [TABLE_DEPTH];
        field_t      shift_by [TABLE_DEPTH];
        int unsigned region_count;
        piece_t      expected_pieces [$];
        int unsigned errors, words_in, words_out, shifted, rejected;

        function new();
            region_count = 0;
            errors = 0;
            words_in = 0;
            words_out = 0;
            shifted = 0;
            rejected = 0;
        endfunction

        // exclusive end, clamped at the top of the address space
        function field_t end_of(field_t first, field_t count);
            if (count > FIELD_MAX - first)
                return FIELD_MAX;
            return first + count;
        endfunction

        function piece_t make_piece(field_t a, field_t b, logic m, status_e st);
            piece_t p;
            p.piece_start = a;
            p.piece_end = b;
            p.mapped = m;
            p.status = st;
            p.last = 1'b0;
            return p;
        endfunction

        function void note_word(logic [1:0] op, field_t dest, field_t src, field_t len,
                                field_t first, field_t count);
            piece_t      batch [$];
            int unsigned pos;
            field_t      cur, stop, cut, b, ie;
            words_in++;
            case (op)
                OP_CLEAR: begin
                    region_count = 0;
                    batch = {batch, make_piece('0, '0, 1'b0, ST_OK)};
                end
                OP_ADD: begin
                    if (region_count >= TABLE_DEPTH) begin
                        rejected++;
                        batch = {batch, make_piece('0, '0, 1'b0, ST_FULL)};
                    end else begin
                        // equal starts go behind the ones already there
                        pos = region_count;
                        while (pos > 0 && lo_bound[pos-1] > src) begin
                            lo_bound[pos] = lo_bound[pos-1];
                            hi_bound[pos] = hi_bound[pos-1];
                            shift_by[pos] = shift_by[pos-1];
                            pos--;
                        end
                        lo_bound[pos] = src;
                        hi_bound[pos] = end_of(src, len);
                        shift_by[pos] = dest - src;
                        region_count++;
                        batch = {batch, make_piece('0, '0, 1'b0, ST_OK)};
                    end
                end
                OP_SPLIT: begin
                    cur = first;
                    stop = end_of(first, count);
                    for (int i = 0; i < region_count && cur < stop; i++) begin
                        cut = (lo_bound[i] < stop) ? lo_bound[i] : stop;
                        if (cut > cur)
                            batch = {batch, make_piece(cur, cut, 1'b0, ST_PIECE)};
                        b = (cur > lo_bound[i]) ? cur : lo_bound[i];
                        ie = (stop < hi_bound[i]) ? stop : hi_bound[i];
                        if (ie > b)
                            batch = {batch, make_piece(b + shift_by[i], ie + shift_by[i],
                                                       1'b1, ST_PIECE)};
                        if (hi_bound[i] > cur)
                            cur = hi_bound[i];
                    end
                    if (cur < stop)
                        batch = {batch, make_piece(cur, stop, 1'b0, ST_PIECE)};
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            expected_pieces = {expected_pieces, batch};
        endfunction

        function void check_piece(field_t start, field_t stop, logic mapped,
                                  logic [1:0] status, logic last);
            piece_t want;
            words_out++;
            if (expected_pieces.size() == 0) begin
                errors++;
                $error("unexpected result word: start %h end %h status %0d",
                       start, stop, status);
                return;
            end
            want = expected_pieces.pop_front();
            if (want.mapped)
                shifted++;
            if (start !== want.piece_start) begin
                errors++;
                $error("piece_start: expected %h, got %h", want.piece_start, start);
            end
            if (stop !== want.piece_end) begin
                errors++;
                $error("piece_end: expected %h, got %h", want.piece_end, stop);
            end
            if (mapped !== want.mapped) begin
                errors++;
                $error("mapped: expected %0d, got %0d", want.mapped, mapped);
            end
            if (status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, status);
            end
            if (last !== want.last) begin
                errors++;
                $error("last: expected %0d, got %0d", want.last, last);
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid, s_ready;
    logic [1:0] s_operation;
    field_t     s_entry_dest, s_entry_source, s_entry_length;
    field_t     s_range_start, s_range_length;
    logic       m_valid, m_ready;
    field_t     m_piece_start, m_piece_end;
    logic       m_mapped, m_last;
    logic [1:0] m_status;

    remap_scoreboard sb;
    int unsigned     words_sent = 0;
    // no idling on either side while set
    bit              calm = 1'b0;
    // asks the receiver for one long hold-off
    logic            hold_request;

    always #6 aclk = ~aclk;

    interval_remap_splitter_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_dest   (s_entry_dest),
        .s_entry_source (s_entry_source),
        .s_entry_length (s_entry_length),
        .s_range_start  (s_range_start),
        .s_range_length (s_range_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_piece_start  (m_piece_start),
        .m_piece_end    (m_piece_end),
        .m_mapped       (m_mapped),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    // full-width random value, every bit toggles
    function automatic field_t rnd48();
        return field_t'({$urandom, $urandom});
    endfunction

    // address in one of three neighborhoods: low, just under the top, anywhere
    function automatic field_t pick_point(int mode);
        case (mode)
            0: return field_t'($urandom_range(0, 1023));
            1: return FIELD_MAX - field_t'($urandom_range(0, 1023));
            default: return rnd48();
        endcase
    endfunction

    // region or range length, mostly short so regions overlap and abut
    function automatic field_t pick_span(int mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return FIELD_MAX;
        if (mode == 2 && roll < 40)
            return rnd48();
        return field_t'($urandom_range(0, 300));
    endfunction

    // offer one word, idling first at random; returns at the accepting edge
    task automatic send_word(logic [1:0] op, field_t dest, field_t src, field_t len,
                             field_t first, field_t count);
        while (!calm && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_entry_dest   <= dest;
        s_entry_source <= src;
        s_entry_length <= len;
        s_range_start  <= first;
        s_range_length <= count;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // both channels observed at the edge, before any update lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(s_operation, s_entry_dest, s_entry_source, s_entry_length,
                             s_range_start, s_range_length);
            if (m_valid && m_ready)
                sb.check_piece(m_piece_start, m_piece_end, m_mapped, m_status, m_last);
        end
    end

    // receiver: random stalls, one long hold-off on request, none while calm
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    // watchdog: too long without any word moving on either channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (aresetn === 1'b1 && ((s_valid && s_ready) || (m_valid && m_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int mode;
        int unsigned n_adds, n_splits;
        field_t first, count;
        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_operation    <= OP_CLEAR;
        s_entry_dest   <= '0;
        s_entry_source <= '0;
        s_entry_length <= '0;
        s_range_start  <= '0;
        s_range_length <= '0;
        hold_request   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: build a full table with the awkward regions, then split across it
        send_word(OP_CLEAR, '0, '0, '0, '0, '0);
        send_word(OP_ADD, 48'd1000, 48'd100, 48'd50, '0, '0);
        // zero length region covers nothing
        send_word(OP_ADD, 48'd5, 48'd120, '0, '0, '0);
        // overlaps the first one, negative shift
        send_word(OP_ADD, '0, 48'd130, 48'd40, '0, '0);
        // same start as an existing region, must land after it
        send_word(OP_ADD, 48'd7000, 48'd100, 48'd10, '0, '0);
        // shifted piece wraps past the top of the address space
        send_word(OP_ADD, FIELD_MAX, '0, 48'd20, '0, '0);
        // end clamps at the limit
        send_word(OP_ADD, '0, FIELD_MAX - 48'd10, FIELD_MAX, '0, '0);
        send_word(OP_ADD, FIELD_MAX, FIELD_MAX, FIELD_MAX, '0, '0);
        // descending starts force the insert to move entries up
        for (int k = 0; k < 9; k++)
            send_word(OP_ADD, 48'h8000_0000_0000 + 48'(37 * k), 48'(700 - 40 * k),
                      48'd25, '0, '0);
        // table is full now
        send_word(OP_ADD, 48'd1, 48'd2, 48'd3, '0, '0);
        send_word(OP_SPLIT, '0, '0, '0, '0, FIELD_MAX);
        // empty ranges: zero length, and a start at the limit
        send_word(OP_SPLIT, '0, '0, '0, 48'd110, '0);
        send_word(OP_SPLIT, '0, '0, '0, FIELD_MAX, 48'd5);
        send_word(OP_SPLIT, '0, '0, '0, 48'd95, 48'd100);
        send_word(OP_UNUSED, rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
        send_word(OP_CLEAR, rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
        send_word(OP_SPLIT, '0, '0, '0, 48'd50, 48'd10);

        // random: mostly clear, a batch of adds, a few splits in one neighborhood
        while (words_sent < ITEM_TARGET) begin
            calm = (words_sent >= 180) && (words_sent < 240);
            if (words_sent >= 100 && !hold_request)
                hold_request <= 1'b1;
            mode = $urandom_range(0, 2);
            // now and then keep the old table, so adds pile up past full
            if ($urandom_range(0, 9) != 0)
                send_word(OP_CLEAR, rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
            n_adds = $urandom_range(0, 20);
            for (int k = 0; k < n_adds; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(OP_UNUSED, rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
                send_word(OP_ADD, $urandom_range(0, 1) ? rnd48() : pick_point(mode),
                          pick_point(mode), pick_span(mode), rnd48(), rnd48());
            end
            n_splits = $urandom_range(1, 6);
            for (int k = 0; k < n_splits; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    first = '0;
                    count = FIELD_MAX;
                end else begin
                    first = pick_point(mode);
                    count = (mode == 2) ? pick_span(mode) : field_t'($urandom_range(0, 700));
                end
                send_word(OP_SPLIT, rnd48(), rnd48(), rnd48(), first, count);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // drain, then give a late stray word time to show up
        while (sb.expected_pieces.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input words and %0d result words", sb.words_in, sb.words_out);
        $display("including %0d shifted pieces and %0d adds refused on a full table",
                 sb.shifted, sb.rejected);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/irs_pkg.sv
hdl/irs_seq.sv
hdl/interval_remap_splitter_top.sv
verif/interval_remap_splitter_top_tb.sv
